// ===== rtl/core/cpx_alu_pkg.sv =====
// Package for the complex fixed point ALU: action codes, default widths
// and the control word that travels along the divider cell row.
// No dependencies.
`timescale 1ns / 1ps

package cpx_alu_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	// control word carried by each divider cell
	typedef struct packed {
		logic valid;
		logic is_div;
		logic div_zero;
		logic byp_ovf;
		logic neg_re;
		logic neg_im;
		logic big_re;
		logic big_im;
	} ctl_t;

endpackage

// ===== rtl/core/cpx_alu_in_if.sv =====
// Operand channel: valid/ready plus action and two complex operands.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpx_alu_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic signed [DATA_WIDTH-1:0] a_real;
	logic signed [DATA_WIDTH-1:0] a_imag;
	logic signed [DATA_WIDTH-1:0] b_real;
	logic signed [DATA_WIDTH-1:0] b_imag;

	modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
	modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== rtl/core/cpx_alu_out_if.sv =====
// Result channel: valid/ready plus complex result and status flags.
// Depends on nothing.
`timescale 1ns / 1ps

interface cpx_alu_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] res_real;
	logic signed [DATA_WIDTH-1:0] res_imag;
	logic                         overflow;
	logic                         div_zero;

	modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
	modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

// ===== rtl/core/cpx_alu_cell.sv =====
// One restoring division cell: produces one quotient bit for both the real
// and imaginary lanes and hands the partial remainders to the next cell.
// Depends on cpx_alu_pkg.
`timescale 1ns / 1ps

module cpx_alu_cell #(
	parameter int DATA_WIDTH = cpx_alu_pkg::DATA_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  cpx_alu_pkg::ctl_t       ctl_i,
	input  logic [2*DATA_WIDTH-1:0] m_i,
	input  logic [2*DATA_WIDTH-1:0] r_re_i,
	input  logic [2*DATA_WIDTH-1:0] r_im_i,
	input  logic [DATA_WIDTH-1:0]   low_re_i,
	input  logic [DATA_WIDTH-1:0]   low_im_i,
	input  logic [DATA_WIDTH-1:0]   q_re_i,
	input  logic [DATA_WIDTH-1:0]   q_im_i,
	input  logic [DATA_WIDTH-1:0]   byp_re_i,
	input  logic [DATA_WIDTH-1:0]   byp_im_i,
	output cpx_alu_pkg::ctl_t       ctl_o,
	output logic [2*DATA_WIDTH-1:0] m_o,
	output logic [2*DATA_WIDTH-1:0] r_re_o,
	output logic [2*DATA_WIDTH-1:0] r_im_o,
	output logic [DATA_WIDTH-1:0]   low_re_o,
	output logic [DATA_WIDTH-1:0]   low_im_o,
	output logic [DATA_WIDTH-1:0]   q_re_o,
	output logic [DATA_WIDTH-1:0]   q_im_o,
	output logic [DATA_WIDTH-1:0]   byp_re_o,
	output logic [DATA_WIDTH-1:0]   byp_im_o
);
	localparam int W  = DATA_WIDTH;
	localparam int TW = 2*W + 1;

	logic [TW-1:0] t_re, t_im, mx, d_re, d_im;
	logic          ge_re, ge_im;

	// trial subtract on both lanes
	always_comb begin
		mx    = {1'b0, m_i};
		t_re  = {r_re_i, low_re_i[W-1]};
		t_im  = {r_im_i, low_im_i[W-1]};
		ge_re = t_re >= mx;
		ge_im = t_im >= mx;
		d_re  = ge_re ? t_re - mx : t_re;
		d_im  = ge_im ? t_im - mx : t_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_o      <= m_i;
			r_re_o   <= d_re[2*W-1:0];
			r_im_o   <= d_im[2*W-1:0];
			low_re_o <= {low_re_i[W-2:0], 1'b0};
			low_im_o <= {low_im_i[W-2:0], 1'b0};
			q_re_o   <= {q_re_i[W-2:0], ge_re};
			q_im_o   <= {q_im_i[W-2:0], ge_im};
			byp_re_o <= byp_re_i;
			byp_im_o <= byp_im_i;
		end
	end

endmodule

// ===== rtl/core/complex_fixed_point_alu.sv =====
// Complex fixed point ALU (add, subtract, multiply, divide) in signed
// Q(DATA_WIDTH-FRAC_BITS).(FRAC_BITS); depends on cpx_alu_pkg, both channel
// interfaces and cpx_alu_cell.
//
// Usage:
//  - operand channel: action, a_real, a_imag, b_real, b_imag; a transfer
//    happens when valid and ready are both high.
//  - result channel: res_real, res_imag, overflow, div_zero, one result
//    per operand transfer, in order.
//  - every action takes the same path from operand transfer to result
//    valid: input register, product stage, sum stage, divider set-up,
//    one cell per quotient bit, output register.
//  - throughput is one item per cycle while the result is not stalled;
//    the row of DATA_WIDTH division cells each resolve one quotient bit
//    of both parts per cycle.
//  - a stalled result holds the whole pipeline: ready drops while the
//    output register is full and not taken.
//  - reset clears all valid flags; no result is shown until new operands
//    arrive.
//  - results saturate with overflow set; a zero divisor gives zero with
//    div_zero set.
`timescale 1ns / 1ps

module complex_fixed_point_alu #(
	parameter int DATA_WIDTH = cpx_alu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cpx_alu_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	cpx_alu_in_if.sink   operand,
	cpx_alu_out_if.source result
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2*W;
	localparam int SW = 2*W + 1;
	localparam int DW = 2*W + F;
	localparam int CW = (W + F > 2*W) ? W + F : 2*W;
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic en;

	// whole pipe moves unless the output register is held
	assign en = !result.valid || result.ready;
	assign operand.ready = en;

	// stage 1: input register
	logic                v_s1;
	cpx_alu_pkg::action_t act_s1;
	logic signed [W-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= cpx_alu_pkg::action_t'(operand.action);
			ar_s1  <= operand.a_real;
			ai_s1  <= operand.a_imag;
			br_s1  <= operand.b_real;
			bi_s1  <= operand.b_imag;
		end
	end

	// stage 2: products and add/subtract
	logic                 v_s2;
	cpx_alu_pkg::action_t act_s2;
	logic signed [PW-1:0] arbr_s2, aibi_s2, aibr_s2, arbi_s2, brbr_s2, bibi_s2;
	logic signed [W:0]    as_re_s2, as_im_s2;
	logic signed [PW-1:0] arx, aix, brx, bix;

	always_comb begin
		arx = PW'(ar_s1);
		aix = PW'(ai_s1);
		brx = PW'(br_s1);
		bix = PW'(bi_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= act_s1;
			arbr_s2 <= arx * brx;
			aibi_s2 <= aix * bix;
			aibr_s2 <= aix * brx;
			arbi_s2 <= arx * bix;
			brbr_s2 <= brx * brx;
			bibi_s2 <= bix * bix;
			if (act_s1 == cpx_alu_pkg::ACT_SUB) begin
				as_re_s2 <= (W+1)'(ar_s1) - (W+1)'(br_s1);
				as_im_s2 <= (W+1)'(ai_s1) - (W+1)'(bi_s1);
			end else begin
				as_re_s2 <= (W+1)'(ar_s1) + (W+1)'(br_s1);
				as_im_s2 <= (W+1)'(ai_s1) + (W+1)'(bi_s1);
			end
		end
	end

	// stage 3: sums of products, saturation of the non-divide results
	logic                 v_s3, div_s3, byp_ovf_s3;
	logic [W-1:0]         byp_re_s3, byp_im_s3;
	logic signed [SW-1:0] nre_s3, nim_s3;
	logic [PW-1:0]        m_s3;
	logic signed [SW-1:0] mre, mim, msum;
	logic signed [SW-1:0] xre, xim;
	logic                 ovre, ovim;
	logic [W-1:0]         sre, sim;

	always_comb begin
		mre  = (SW'(arbr_s2) - SW'(aibi_s2)) >>> F;
		mim  = (SW'(aibr_s2) + SW'(arbi_s2)) >>> F;
		msum = SW'(brbr_s2) + SW'(bibi_s2);
		if (act_s2 == cpx_alu_pkg::ACT_MUL) begin
			xre = mre;
			xim = mim;
		end else begin
			xre = SW'(as_re_s2);
			xim = SW'(as_im_s2);
		end
		// out of range when the bits above the sign are not all copies of it
		ovre = (xre[SW-1:W-1] != '0) && (xre[SW-1:W-1] != '1);
		ovim = (xim[SW-1:W-1] != '0) && (xim[SW-1:W-1] != '1);
		sre  = ovre ? (xre[SW-1] ? SMIN : SMAX) : xre[W-1:0];
		sim  = ovim ? (xim[SW-1] ? SMIN : SMAX) : xim[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s3     <= act_s2 == cpx_alu_pkg::ACT_DIV;
			byp_re_s3  <= sre;
			byp_im_s3  <= sim;
			byp_ovf_s3 <= ovre || ovim;
			nre_s3     <= SW'(arbr_s2) + SW'(aibi_s2);
			nim_s3     <= SW'(aibr_s2) - SW'(arbi_s2);
			m_s3       <= msum[PW-1:0];
		end
	end

	// stage 4: divider set-up; quotient bits at 2^W and above only flag overflow
	logic [SW-1:0] mag_re, mag_im;
	logic [DW-1:0] dd_re, dd_im;
	logic [CW-1:0] top_re, top_im, mcw;
	cpx_alu_pkg::ctl_t ctl_s4;

	always_comb begin
		mag_re = nre_s3[SW-1] ? SW'(-nre_s3) : SW'(nre_s3);
		mag_im = nim_s3[SW-1] ? SW'(-nim_s3) : SW'(nim_s3);
		dd_re  = {mag_re[PW-1:0], {F{1'b0}}};
		dd_im  = {mag_im[PW-1:0], {F{1'b0}}};
		top_re = CW'(dd_re[DW-1:W]);
		top_im = CW'(dd_im[DW-1:W]);
		mcw    = CW'(m_s3);
		ctl_s4.valid    = v_s3;
		ctl_s4.is_div   = div_s3;
		ctl_s4.div_zero = div_s3 && (m_s3 == '0);
		ctl_s4.byp_ovf  = byp_ovf_s3;
		ctl_s4.neg_re   = nre_s3[SW-1];
		ctl_s4.neg_im   = nim_s3[SW-1];
		ctl_s4.big_re   = top_re >= mcw;
		ctl_s4.big_im   = top_im >= mcw;
	end

	// cell row
	cpx_alu_pkg::ctl_t ctl_c [0:W];
	logic [PW-1:0] m_c    [0:W];
	logic [PW-1:0] r_re_c [0:W];
	logic [PW-1:0] r_im_c [0:W];
	logic [W-1:0]  lo_re_c[0:W];
	logic [W-1:0]  lo_im_c[0:W];
	logic [W-1:0]  q_re_c [0:W];
	logic [W-1:0]  q_im_c [0:W];
	logic [W-1:0]  by_re_c[0:W];
	logic [W-1:0]  by_im_c[0:W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (en) begin
			ctl_c[0] <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_c[0]     <= m_s3;
			r_re_c[0]  <= top_re[PW-1:0];
			r_im_c[0]  <= top_im[PW-1:0];
			lo_re_c[0] <= dd_re[W-1:0];
			lo_im_c[0] <= dd_im[W-1:0];
			q_re_c[0]  <= '0;
			q_im_c[0]  <= '0;
			by_re_c[0] <= byp_re_s3;
			by_im_c[0] <= byp_im_s3;
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_cell
		cpx_alu_cell #(
			.DATA_WIDTH(W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_c[i]),
			.m_i      (m_c[i]),
			.r_re_i   (r_re_c[i]),
			.r_im_i   (r_im_c[i]),
			.low_re_i (lo_re_c[i]),
			.low_im_i (lo_im_c[i]),
			.q_re_i   (q_re_c[i]),
			.q_im_i   (q_im_c[i]),
			.byp_re_i (by_re_c[i]),
			.byp_im_i (by_im_c[i]),
			.ctl_o    (ctl_c[i+1]),
			.m_o      (m_c[i+1]),
			.r_re_o   (r_re_c[i+1]),
			.r_im_o   (r_im_c[i+1]),
			.low_re_o (lo_re_c[i+1]),
			.low_im_o (lo_im_c[i+1]),
			.q_re_o   (q_re_c[i+1]),
			.q_im_o   (q_im_c[i+1]),
			.byp_re_o (by_re_c[i+1]),
			.byp_im_o (by_im_c[i+1])
		);
	end

	// final: sign, saturate and select
	cpx_alu_pkg::ctl_t ce;
	logic [W-1:0] qre, qim, fre, fim;
	logic         ofre, ofim, fovf;

	always_comb begin
		ce  = ctl_c[W];
		qre = q_re_c[W];
		qim = q_im_c[W];
		// negative side reaches one step further than positive
		if (ce.neg_re) begin
			ofre = ce.big_re || (qre[W-1] && (qre[W-2:0] != '0));
		end else begin
			ofre = ce.big_re || qre[W-1];
		end
		if (ce.neg_im) begin
			ofim = ce.big_im || (qim[W-1] && (qim[W-2:0] != '0));
		end else begin
			ofim = ce.big_im || qim[W-1];
		end
		if (!ce.is_div) begin
			fre  = by_re_c[W];
			fim  = by_im_c[W];
			fovf = ce.byp_ovf;
		end else if (ce.div_zero) begin
			fre  = '0;
			fim  = '0;
			fovf = 1'b0;
		end else begin
			fre  = ofre ? (ce.neg_re ? SMIN : SMAX) : (ce.neg_re ? W'(-qre) : qre);
			fim  = ofim ? (ce.neg_im ? SMIN : SMAX) : (ce.neg_im ? W'(-qim) : qim);
			fovf = ofre || ofim;
		end
	end

	// output register
	logic         ov_q, ovf_q, dz_q;
	logic [W-1:0] rre_q, rim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (en) begin
			ov_q <= ce.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rre_q <= fre;
			rim_q <= fim;
			ovf_q <= fovf;
			dz_q  <= ce.div_zero;
		end
	end

	assign result.valid    = ov_q;
	assign result.res_real = rre_q;
	assign result.res_imag = rim_q;
	assign result.overflow = ovf_q;
	assign result.div_zero = dz_q;

`ifndef SYNTHESIS
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.div_zero) |->
		(result.res_real == '0 && result.res_imag == '0 && !result.overflow))
		else $error("divide by zero result not cleared");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.overflow) |->
		(rre_q == SMAX || rre_q == SMIN || rim_q == SMAX || rim_q == SMIN))
		else $error("overflow flagged without a saturated part");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		operand.ready == (!result.valid || result.ready))
		else $error("operand ready does not follow output stall");
`endif

endmodule

// ===== tb/cpx_alu_checker.sv =====
// Result checker for the complex fixed point ALU: watches both channels,
// predicts each result from the operands and compares field by field.
// Depends on cpx_alu_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module cpx_alu_checker (
	input  logic          clk,
	input  logic          arst_n,
	cpx_alu_in_if         operand,
	cpx_alu_out_if        result,
	output int            fail_count,
	output int            pending,
	output int            n_results,
	output int            n_ovf,
	output int            n_dz
);
	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
		logic               ovf;
		logic               dz;
	} cpx_res_t;

	cpx_res_t expected_q[$];

	// clamp a wide value to 32 signed bits
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
			inout logic ovf);
		logic signed [127:0] hi_lim;
		logic signed [127:0] lo_lim;
		hi_lim = 128'sd2147483647;
		lo_lim = -128'sd2147483648;
		if (v > hi_lim) begin
			ovf = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < lo_lim) begin
			ovf = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// numerator * 2^16 / m, truncated toward zero
	function automatic logic signed [127:0] frac_div(input logic signed [127:0] num,
			input logic signed [127:0] m);
		logic [127:0] mag;
		logic [127:0] q;
		mag = num[127] ? -num : num;
		q = (mag << 16) / m;
		return num[127] ? -$signed(q) : $signed(q);
	endfunction

	function automatic cpx_res_t predict_result(input cpx_alu_pkg::action_t act,
			input logic signed [31:0] ar, input logic signed [31:0] ai,
			input logic signed [31:0] br, input logic signed [31:0] bi);
		logic signed [127:0] xr, xi, yr, yi, re, im, m;
		cpx_res_t r;
		xr = ar; xi = ai; yr = br; yi = bi;
		r = '0;
		case (act)
			cpx_alu_pkg::ACT_ADD: begin
				re = xr + yr; im = xi + yi;
			end
			cpx_alu_pkg::ACT_SUB: begin
				re = xr - yr; im = xi - yi;
			end
			cpx_alu_pkg::ACT_MUL: begin
				re = (xr * yr - xi * yi) >>> 16;
				im = (xi * yr + xr * yi) >>> 16;
			end
			default: begin
				m = yr * yr + yi * yi;
				if (m == 0) begin
					r.dz = 1'b1; re = 0; im = 0;
				end else begin
					re = frac_div(xr * yr + xi * yi, m);
					im = frac_div(xi * yr - xr * yi, m);
				end
			end
		endcase
		r.re = clamp32(re, r.ovf);
		r.im = clamp32(im, r.ovf);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		cpx_res_t e;
		cpx_res_t got;
		if (!arst_n) begin
			expected_q.delete();
			fail_count <= 0;
			n_results <= 0;
			n_ovf <= 0;
			n_dz <= 0;
		end else begin
			if (operand.valid && operand.ready)
				expected_q.push_back(predict_result(
						cpx_alu_pkg::action_t'(operand.action),
						operand.a_real, operand.a_imag, operand.b_real, operand.b_imag));
			if (result.valid && result.ready) begin
				got = '{result.res_real, result.res_imag, result.overflow, result.div_zero};
				n_results <= n_results + 1;
				n_ovf <= n_ovf + got.ovf;
				n_dz <= n_dz + got.dz;
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("checker: result transfer with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e !== got) begin
						if (fail_count < 10)
							$display({"checker: mismatch exp re=%h im=%h ovf=%b dz=%b,",
									" got re=%h im=%h ovf=%b dz=%b"},
									e.re, e.im, e.ovf, e.dz,
									got.re, got.im, got.ovf, got.dz);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

// ===== tb/tb.sv =====
// Testbench top for complex_fixed_point_alu: directed and random operand
// stimulus with random gaps and stalls; verdict from cpx_alu_checker.
// Depends on cpx_alu_pkg, the channel interfaces and the checker.
`timescale 1ns / 1ps

module tb;
	localparam int LATENCY   = 36;
	localparam int N_RANDOM  = 730;
	localparam int WDOG_MAX  = 2000;

	logic clk;
	logic arst_n;
	int   fail_count, pending, n_results, n_ovf, n_dz;
	int   idle_cycles;
	int   n_sent;
	logic timed_out;

	cpx_alu_in_if  operand ();
	cpx_alu_out_if result ();

	complex_fixed_point_alu u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand),
		.result (result)
	);

	cpx_alu_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.operand   (operand),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending),
		.n_results (n_results),
		.n_ovf     (n_ovf),
		.n_dz      (n_dz)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((operand.valid && operand.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// a run with no transfers for too long ends here
	initial begin
		timed_out = 1'b0;
		wait (idle_cycles >= WDOG_MAX);
		timed_out = 1'b1;
		$display("Stopped after %0d operand transfers and %0d results: no transfer for %0d cycles.",
				n_sent, n_results, WDOG_MAX);
		$display("FAIL");
		$finish;
	end

	// result side: random stall, sometimes long stretches with none
	initial begin
		int wait_n;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (n_sent % 200 < 60) wait_n = 0;
			if (wait_n > 0) begin
				result.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// drive one operand transfer, with a leading gap
	task automatic send_operands(input cpx_alu_pkg::action_t act, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi,
			input int gap);
		if (gap > 0) begin
			operand.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operand.valid  <= 1'b1;
		operand.action <= act;
		operand.a_real <= ar;
		operand.a_imag <= ai;
		operand.b_real <= br;
		operand.b_imag <= bi;
		do @(posedge clk); while (!operand.ready);
		@(negedge clk);
		n_sent++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
			4: return $signed($urandom_range(0, 2047)) - 1024;
			5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [31:0] ext[4];
		int gap;
		logic [31:0] br, bi;
		ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
		idle_cycles = 0;
		n_sent = 0;
		arst_n = 1'b0;
		operand.valid = 1'b0;
		operand.action = cpx_alu_pkg::ACT_ADD;
		operand.a_real = '0;
		operand.a_imag = '0;
		operand.b_real = '0;
		operand.b_imag = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes per action, division by zero, unit values
		for (int a = 0; a < 4; a++) begin
			send_operands(cpx_alu_pkg::action_t'(a), ext[0], ext[1], ext[0], ext[0], 0);
			send_operands(cpx_alu_pkg::action_t'(a), ext[1], ext[0], ext[1], ext[1], 0);
			send_operands(cpx_alu_pkg::action_t'(a), 32'h00010000, 32'h00020000,
					32'h00010000, ext[3], 1);
			send_operands(cpx_alu_pkg::action_t'(a), ext[2], ext[3], ext[3], ext[2], 0);
		end
		send_operands(cpx_alu_pkg::ACT_DIV, 32'h00030000, 32'hfffd0000, 32'h0, 32'h0, 0);
		send_operands(cpx_alu_pkg::ACT_DIV, ext[0], ext[1], 32'h00000001, 32'h0, 0);
		send_operands(cpx_alu_pkg::ACT_MUL, 32'h00008000, 32'hffff8000, 32'hffff8000,
				32'h1, 2);

		// hold off until every expected result is in
		operand.valid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);

		// random part
		for (int i = 0; i < N_RANDOM && !timed_out; i++) begin
			gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
			if (i % 250 < 50) gap = 0;
			br = pick_value();
			bi = pick_value();
			if ($urandom_range(0, 15) == 0) begin
				br = 0; bi = 0;
			end
			send_operands(cpx_alu_pkg::action_t'($urandom_range(0, 3)), pick_value(),
					pick_value(), br, bi, gap);
		end
		operand.valid <= 1'b0;

		wait (pending == 0 || timed_out);
		repeat (LATENCY + 5) @(negedge clk);
		$display("Ran %0d operand transfers over all four actions; %0d results,",
				n_sent, n_results);
		$display("%0d saturated, %0d divides by zero, with random gaps and result stalls.",
				n_ovf, n_dz);
		if (!timed_out && fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/cpx_alu_pkg.sv
rtl/core/cpx_alu_in_if.sv
rtl/core/cpx_alu_out_if.sv
rtl/core/cpx_alu_cell.sv
rtl/core/complex_fixed_point_alu.sv
tb/cpx_alu_checker.sv
tb/tb.sv
